>>> hw/rtl/lspf_pkg.sv
// ----------------------------------------------------------------------------
// lspf_pkg
// Shared types and constants of the lidar scan packet forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package lspf_pkg;

   // Frame framing bytes
   localparam logic [7:0] FRAME_HEAD0 = 8'hFD;
   localparam logic [7:0] FRAME_HEAD1 = 8'hFC;
   localparam logic [7:0] FRAME_TAIL  = 8'hFF;

   // Configuration register indexes and reset values
   localparam logic CSR_DIST_LOW_MIN    = 1'b0;
   localparam logic CSR_DIST_HIGH_LIMIT = 1'b1;
   localparam logic [7:0] DIST_LOW_MIN_RESET    = 8'd32;
   localparam logic [7:0] DIST_HIGH_LIMIT_RESET = 8'h0F;

   // Packet queue geometry
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Frame position counter: eight bytes per frame
   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned FPOS_W    = $clog2(FRAME_LEN);

   // Parser phases
   typedef enum logic [4:0] {
      PH_START = 5'b00001,
      PH_CHECK = 5'b00010,
      PH_THIRD = 5'b00100,
      PH_LOW   = 5'b01000,
      PH_HIGH  = 5'b10000
   } phase_type;

   // One complete scan packet, byte 0 first
   typedef struct packed {
      logic [7:0] b4;
      logic [7:0] b3;
      logic [7:0] b2;
      logic [7:0] b1;
      logic [7:0] b0;
   } packet_type;

   // Queue status seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

>>> hw/rtl/lspf_parse.sv
// ----------------------------------------------------------------------------
// lspf_parse
// Front end: checks incoming bytes and pushes each complete packet that passes the checks.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                csr_wen,
   input  wire logic                csr_index,
   input  wire logic [7:0]          csr_wdata,
   input  wire lspf_pkg::qstat_type q_stat,
   output logic                     q_push,
   output lspf_pkg::packet_type     q_data
);
   import lspf_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] low_min_ff, low_min_in;
   logic [7:0] high_lim_ff, high_lim_in;
   logic [7:0] s0_ff, s1_ff, s2_ff, s3_ff;
   logic       accept;

   // Stall only when a packet would complete into a full queue
   assign req_tready = !((phase_ff == PH_HIGH) && q_stat.full);
   assign accept     = req_tvalid && req_tready;

   assign q_push = accept && (phase_ff == PH_HIGH) && (req_tdata < high_lim_ff);
   assign q_data = '{b4: req_tdata, b3: s3_ff, b2: s2_ff, b1: s1_ff, b0: s0_ff};

   // Advance the phase on each accepted item
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_START: phase_in = (req_tdata[0] != req_tdata[1]) ? PH_CHECK : PH_START;
            PH_CHECK: phase_in = req_tdata[0] ? PH_THIRD : PH_START;
            PH_THIRD: phase_in = PH_LOW;
            PH_LOW:   phase_in = (req_tdata > low_min_ff) ? PH_HIGH : PH_START;
            PH_HIGH:  phase_in = PH_START;
            default:  phase_in = PH_START;
         endcase
      end
   end

   // Decode configuration writes
   always_comb begin
      low_min_in  = low_min_ff;
      high_lim_in = high_lim_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_DIST_LOW_MIN:    low_min_in  = csr_wdata;
            CSR_DIST_HIGH_LIMIT: high_lim_in = csr_wdata;
            default:             low_min_in  = low_min_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         low_min_ff  <= DIST_LOW_MIN_RESET;
         high_lim_ff <= DIST_HIGH_LIMIT_RESET;
      end else begin
         phase_ff    <= phase_in;
         low_min_ff  <= low_min_in;
         high_lim_ff <= high_lim_in;
      end
   end

   // Hold the packet bytes; later phases overwrite only on their own byte
   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_START)) s0_ff <= req_tdata;
      if (accept && (phase_ff == PH_CHECK)) s1_ff <= req_tdata;
      if (accept && (phase_ff == PH_THIRD)) s2_ff <= req_tdata;
      if (accept && (phase_ff == PH_LOW))   s3_ff <= req_tdata;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lspf_queue.sv
// ----------------------------------------------------------------------------
// lspf_queue
// Short packet queue between the parser and the frame emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lspf_pkg::packet_type push_data,
   input  wire logic                 pop,
   output lspf_pkg::packet_type      pop_data,
   output lspf_pkg::qstat_type       stat
);
   import lspf_pkg::*;

   packet_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = entry_ff[rptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed packet
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lspf_emit.sv
// ----------------------------------------------------------------------------
// lspf_emit
// Back end: turns each queued packet into an eight-byte output frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lspf_pkg::qstat_type  q_stat,
   input  wire lspf_pkg::packet_type q_data,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import lspf_pkg::*;

   logic              busy_ff, busy_in;
   logic [FPOS_W-1:0] pos_ff, pos_in;
   packet_type        pkt_ff;
   logic              take, done;

   assign rsp_tvalid = busy_ff;
   assign take       = busy_ff && rsp_tready;
   assign done       = take && (pos_ff == FPOS_W'(FRAME_LEN - 1));
   assign q_pop      = !q_stat.empty && (!busy_ff || done);

   // Select the frame byte at the current position
   always_comb begin
      case (pos_ff)
         3'd0:    rsp_tdata = FRAME_HEAD0;
         3'd1:    rsp_tdata = FRAME_HEAD1;
         3'd2:    rsp_tdata = pkt_ff.b0;
         3'd3:    rsp_tdata = pkt_ff.b1;
         3'd4:    rsp_tdata = pkt_ff.b2;
         3'd5:    rsp_tdata = pkt_ff.b3;
         3'd6:    rsp_tdata = pkt_ff.b4;
         default: rsp_tdata = FRAME_TAIL;
      endcase
   end
   assign rsp_tlast = (pos_ff == FPOS_W'(FRAME_LEN - 1));

   // Step through the frame, reload from the queue at its end or when idle
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (take) pos_in = pos_ff + 1'b1;
      if (done) busy_in = 1'b0;
      if (q_pop) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) pkt_ff <= q_data;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lidar_scan_packet_forwarder.sv
// ----------------------------------------------------------------------------
// lidar_scan_packet_forwarder
// Finds checked 5-byte lidar scan packets and forwards each as a framed
// 8-byte burst: FD, FC, five packet bytes, FF.
//
//   channel  dir  handshake          payload
//   req      in   tvalid/tready      tdata[7:0] rx_byte
//   rsp      out  tvalid/tready      tdata[7:0] tx_byte, tlast frame_last
//   csr      in   wen (no wait)      index[0], wdata[7:0]
//
// One byte is accepted per cycle while req_tready is high. A finished packet
// enters a two-entry queue and leaves as eight bytes, one per rsp handshake;
// that output serializer sets the sustained frame rate.
// req_tready drops only on the last byte of a packet while the queue is full.
// Reset is synchronous, active high, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_scan_packet_forwarder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] tx_byte
   output logic            rsp_tlast,
   input  wire logic       csr_wen,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);
   import lspf_pkg::*;

   qstat_type  q_stat;
   packet_type push_data, pop_data;
   logic       push, pop;

   lspf_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .q_push     (push),
      .q_data     (push_data)
   );

   lspf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   lspf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_data     (pop_data),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
